[hw/rtl/jsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and codes of the JSON string decoder
// Input and result word layouts, the queued job format and the kind codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  // characters with a meaning of their own
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       run_last;
  } out_word_t;

  // one input byte's worth of results: up to three bytes, last index 0..2
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] last_idx;
    logic [1:0] kind;
  } job_t;

endpackage

[hw/rtl/json_string_unescape_utf8_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core - streaming JSON string decoder
// Decodes escapes and \u code points of a JSON string literal into UTF-8.
// ----------------------------------------------------------------------------
// One raw byte is accepted per cycle, back to back, as long as the job queue
// (DEPTH entries) has room. The parser settles each byte in its accept cycle
// and queues the results it causes; the emitter sends one result per cycle
// while the output is not stalled, so a completed \u escape sends its one to
// three bytes one after another. Since such an escape needs six input bytes,
// one byte per cycle is sustained. On the way out a result is registered
// twice: its job is written into the queue at the accept edge and later
// loaded from the queue head into the output register.
module json_string_unescape_utf8_core #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsu_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_word_t out_data
);

  logic          acc, push, pop, empty, full;
  jsu_pkg::job_t push_job, head;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job)
  );

  jsu_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/jsu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front - parse state machine
// Takes one raw byte per word, tracks the string phase and hex escapes, and
// hands the queue a job describing the results of that byte, if it has any.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  jsu_pkg::in_word_t in_data,
  output logic             push,
  output jsu_pkg::job_t    push_job
);

  typedef enum logic [1:0] {
    PH_AWAIT = 2'd0,
    PH_BODY  = 2'd1,
    PH_ESC   = 2'd2,
    PH_HEX   = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [15:0] cp_shift;
  logic [3:0]  hv;
  logic        hv_ok;
  logic [7:0]  c;
  logic        last;
  logic [7:0]  esc_map;

  assign c    = in_data.char_byte;
  assign last = in_data.final_byte;

  // hex digit value
  always_comb begin
    hv    = 4'd0;
    hv_ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) begin
      hv = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hv = c[3:0] + 4'd9;
    end else begin
      hv_ok = 1'b0;
    end
  end

  assign cp_shift = {cp_r[11:0], hv};

  // single-character escapes
  always_comb begin
    unique case (c)
      8'h62:   esc_map = 8'h08;
      8'h66:   esc_map = 8'h0C;
      8'h6E:   esc_map = 8'h0A;
      8'h72:   esc_map = 8'h0D;
      8'h74:   esc_map = 8'h09;
      default: esc_map = c;
    endcase
  end

  // next state and job
  always_comb begin
    phase_nxt   = phase_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    push        = 1'b0;
    push_job    = '0;
    unique case (phase_r)
      PH_AWAIT: begin
        if (c != jsu_pkg::CH_QUOTE || last) begin
          push          = 1'b1;
          push_job.kind = jsu_pkg::KIND_BAD;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          phase_nxt     = PH_AWAIT;
          push          = 1'b1;
          push_job.kind = jsu_pkg::KIND_DONE;
        end else if (last) begin
          push          = 1'b1;
          push_job.kind = jsu_pkg::KIND_BAD;
        end else if (c == jsu_pkg::CH_BSL) begin
          phase_nxt = PH_ESC;
        end else begin
          push          = 1'b1;
          push_job.kind = jsu_pkg::KIND_DATA;
          push_job.b0   = c;
        end
      end
      PH_ESC: begin
        if (last) begin
          push          = 1'b1;
          push_job.kind = jsu_pkg::KIND_BAD;
        end else if (c == jsu_pkg::CH_U) begin
          phase_nxt   = PH_HEX;
          hex_cnt_nxt = 2'd0;
          cp_nxt      = 16'd0;
        end else begin
          phase_nxt     = PH_BODY;
          push          = 1'b1;
          push_job.kind = jsu_pkg::KIND_DATA;
          push_job.b0   = esc_map;
        end
      end
      PH_HEX: begin
        if (last || !hv_ok) begin
          push          = 1'b1;
          push_job.kind = jsu_pkg::KIND_BAD;
        end else begin
          cp_nxt = cp_shift;
          if (hex_cnt_r != 2'd3) begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end else begin
            // fourth digit: encode the code point as UTF-8
            hex_cnt_nxt   = 2'd0;
            phase_nxt     = PH_BODY;
            push          = 1'b1;
            push_job.kind = jsu_pkg::KIND_DATA;
            if (cp_shift <= 16'h007F) begin
              push_job.b0       = cp_shift[7:0];
              push_job.last_idx = 2'd0;
            end else if (cp_shift <= 16'h07FF) begin
              push_job.b0       = 8'hC0 | {3'b000, cp_shift[10:6]};
              push_job.b1       = 8'h80 | {2'b00, cp_shift[5:0]};
              push_job.last_idx = 2'd1;
            end else begin
              push_job.b0       = 8'hE0 | {4'h0, cp_shift[15:12]};
              push_job.b1       = 8'h80 | {2'b00, cp_shift[11:6]};
              push_job.b2       = 8'h80 | {2'b00, cp_shift[5:0]};
              push_job.last_idx = 2'd2;
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_AWAIT;
      end
    endcase
    // any malformed report drops back to awaiting a quote
    if (push && push_job.kind == jsu_pkg::KIND_BAD) begin
      phase_nxt   = PH_AWAIT;
      hex_cnt_nxt = 2'd0;
      cp_nxt      = 16'd0;
    end
    if (!acc) begin
      phase_nxt   = phase_r;
      hex_cnt_nxt = hex_cnt_r;
      cp_nxt      = cp_r;
      push        = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_AWAIT;
      hex_cnt_r <= 2'd0;
      cp_r      <= 16'd0;
    end else begin
      phase_r   <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
    end
  end

endmodule

[hw/rtl/jsu_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_fifo - job queue between parser and emitter
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  input  logic          pop,
  output jsu_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  jsu_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_MAX);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hw/rtl/jsu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back - result emitter
// Walks the head job's bytes to the output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jsu_pkg::job_t      head,
  input  logic               empty,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output jsu_pkg::out_word_t out_data
);

  logic                 out_valid_r;
  jsu_pkg::out_word_t   out_data_r;
  jsu_pkg::out_word_t   word_nxt;
  logic [1:0]           idx_r, idx_nxt;
  logic                 load, take, at_last;

  assign load    = !out_valid_r || !out_stall;
  assign take    = load && !empty;
  assign at_last = (idx_r == head.last_idx);
  assign pop     = take && at_last;

  // pick the current byte of the job
  always_comb begin
    word_nxt          = '0;
    word_nxt.out_kind = head.kind;
    word_nxt.run_last = at_last;
    if (head.kind == jsu_pkg::KIND_DATA) begin
      unique case (idx_r)
        2'd0:    word_nxt.out_byte = head.b0;
        2'd1:    word_nxt.out_byte = head.b1;
        default: word_nxt.out_byte = head.b2;
      endcase
    end
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/jsu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker - port-level checks of the JSON string decoder
// Watches the result channel and the input stall, and is bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input jsu_pkg::out_word_t out_data
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // status reports close the run of their byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind != jsu_pkg::KIND_DATA |-> out_data.run_last)
    else $error("status report not last of its run");

  // status reports carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind != jsu_pkg::KIND_DATA |-> out_data.out_byte == 8'd0)
    else $error("status report with non-zero byte");

  // no unused kind code
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_kind != 2'd3)
    else $error("unused result kind");

  // a stalled input with an idle output is impossible: the queue drains
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid)
    else $error("input stalled while output idle");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (.*);

[bench/json_string_unescape_utf8_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core_test - self-checking bench of the decoder
// Feeds JSON string literals byte by byte, well formed and broken, with
// random gaps and output stalls, and checks every result word against a
// decoder model kept inside the bench.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_BYTES  = 200;

  // escape letters and their control bytes
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CTL_BS   = 8'h08;
  localparam logic [7:0] CTL_FF   = 8'h0C;
  localparam logic [7:0] CTL_LF   = 8'h0A;
  localparam logic [7:0] CTL_CR   = 8'h0D;
  localparam logic [7:0] CTL_TAB  = 8'h09;
  // hex digit bases
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  typedef enum logic [1:0] {
    PH_AWAIT, PH_BODY, PH_ESC, PH_HEX
  } parse_phase_t;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  jsu_pkg::in_word_t  in_data  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  jsu_pkg::out_word_t out_data;

  jsu_pkg::in_word_t  text_q[$];     // bytes still to be fed
  jsu_pkg::out_word_t decoded_q[$];  // result words still to arrive
  parse_phase_t       dec_phase;
  logic [1:0]         dec_digits;
  logic [15:0]        dec_cp;
  int                 err_cnt;
  int                 cyc;
  int                 feed_hold;
  int                 sink_hold;
  bit                 feed_calm;
  bit                 sink_calm;

  json_string_unescape_utf8_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // value of a hex digit, -1 for any other byte
  function automatic int hex_nibble(logic [7:0] c);
    if (c >= CH_0 && c <= CH_0 + 8'd9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LA + 8'd5) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UA + 8'd5) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic jsu_pkg::out_word_t make_word(logic [7:0] b, logic [1:0] kind);
    jsu_pkg::out_word_t w;
    w.out_byte = b;
    w.out_kind = kind;
    w.run_last = 1'b0;
    return w;
  endfunction

  // decoder model: advance the state by one byte, queue the words it causes
  function automatic void decode_byte(jsu_pkg::in_word_t w);
    jsu_pkg::out_word_t res[$];
    logic [7:0]         c;
    logic [7:0]         m;
    logic               fin;
    bit                 broken;
    int                 hv;
    c      = w.char_byte;
    fin    = w.final_byte;
    broken = 1'b0;
    case (dec_phase)
      PH_AWAIT: begin
        if (c != jsu_pkg::CH_QUOTE || fin) broken = 1'b1;
        else dec_phase = PH_BODY;
      end
      PH_BODY: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          dec_phase = PH_AWAIT;
          res = {res, make_word(8'h00, jsu_pkg::KIND_DONE)};
        end else if (fin) begin
          broken = 1'b1;
        end else if (c == jsu_pkg::CH_BSL) begin
          dec_phase = PH_ESC;
        end else begin
          res = {res, make_word(c, jsu_pkg::KIND_DATA)};
        end
      end
      PH_ESC: begin
        if (fin) begin
          broken = 1'b1;
        end else if (c == jsu_pkg::CH_U) begin
          dec_phase  = PH_HEX;
          dec_digits = '0;
          dec_cp     = '0;
        end else begin
          case (c)
            CH_B:    m = CTL_BS;
            CH_F:    m = CTL_FF;
            CH_N:    m = CTL_LF;
            CH_R:    m = CTL_CR;
            CH_T:    m = CTL_TAB;
            default: m = c;
          endcase
          dec_phase = PH_BODY;
          res = {res, make_word(m, jsu_pkg::KIND_DATA)};
        end
      end
      default: begin
        hv = hex_nibble(c);
        if (fin || hv < 0) begin
          broken = 1'b1;
        end else begin
          dec_cp = {dec_cp[11:0], hv[3:0]};
          if (dec_digits != 2'd3) begin
            dec_digits = dec_digits + 2'd1;
          end else begin
            dec_digits = '0;
            dec_phase  = PH_BODY;
            // UTF-8 encoding of the 16-bit code point
            if (dec_cp <= 16'h007F) begin
              res = {res, make_word(dec_cp[7:0], jsu_pkg::KIND_DATA)};
            end else if (dec_cp <= 16'h07FF) begin
              res = {res, make_word({3'b110, dec_cp[10:6]}, jsu_pkg::KIND_DATA)};
              res = {res, make_word({2'b10, dec_cp[5:0]}, jsu_pkg::KIND_DATA)};
            end else begin
              res = {res, make_word({4'b1110, dec_cp[15:12]}, jsu_pkg::KIND_DATA)};
              res = {res, make_word({2'b10, dec_cp[11:6]}, jsu_pkg::KIND_DATA)};
              res = {res, make_word({2'b10, dec_cp[5:0]}, jsu_pkg::KIND_DATA)};
            end
          end
        end
      end
    endcase
    if (broken) begin
      dec_phase  = PH_AWAIT;
      dec_digits = '0;
      dec_cp     = '0;
      res = {res, make_word(8'h00, jsu_pkg::KIND_BAD)};
    end
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    foreach (res[i]) decoded_q = {decoded_q, res[i]};
  endfunction

  // per-word wait, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(ref bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %0s at cycle %0d: got 0x%0h, want 0x%0h",
             field, cyc, got, want);
    err_cnt++;
  endtask

  function automatic void queue_byte(logic [7:0] c, logic fin);
    jsu_pkg::in_word_t w;
    w.char_byte  = c;
    w.final_byte = fin;
    text_q = {text_q, w};
  endfunction

  // one random text: mostly well formed strings, some broken ones
  task automatic add_text();
    logic [7:0]  s[$];
    logic [7:0]  c;
    logic [15:0] cp;
    int          n;
    int          k;
    int          v;
    int          pos;
    s = {s, jsu_pkg::CH_QUOTE};
    n = $urandom_range(0, 6);
    repeat (n) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        // plain byte
        do c = 8'($urandom_range(0, 255));
        while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL);
        s = {s, c};
      end else if (k < 7) begin
        // single-letter escape or a literal escaped byte
        s = {s, jsu_pkg::CH_BSL};
        case ($urandom_range(0, 8))
          0:       c = jsu_pkg::CH_QUOTE;
          1:       c = jsu_pkg::CH_BSL;
          2:       c = CH_SLASH;
          3:       c = CH_B;
          4:       c = CH_F;
          5:       c = CH_N;
          6:       c = CH_R;
          7:       c = CH_T;
          default: do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::CH_U);
        endcase
        s = {s, c};
      end else begin
        // \u escape, spread over the one, two and three byte ranges
        s = {s, jsu_pkg::CH_BSL};
        s = {s, jsu_pkg::CH_U};
        case ($urandom_range(0, 3))
          0: cp = 16'($urandom_range(0, 16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          default: begin
            case ($urandom_range(0, 5))
              0: cp = 16'h0000;
              1: cp = 16'h007F;
              2: cp = 16'h0080;
              3: cp = 16'h07FF;
              4: cp = 16'h0800;
              default: cp = 16'hFFFF;
            endcase
          end
        endcase
        for (k = 3; k >= 0; k--) begin
          v = int'(cp[k*4 +: 4]);
          if (v < 10) c = CH_0 + 8'(v);
          else c = ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
          s = {s, c};
        end
      end
    end
    s = {s, jsu_pkg::CH_QUOTE};

    if ($urandom_range(0, 4) != 0) begin
      foreach (s[i])
        queue_byte(s[i], (i == s.size() - 1) && ($urandom_range(0, 1) != 0));
      // junk after the close now and then
      if ($urandom_range(0, 5) == 0)
        queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          // text ends before the closing quote
          pos = (s.size() > 2) ? $urandom_range(1, s.size() - 2) : 0;
          for (k = 0; k <= pos; k++) queue_byte(s[k], k == pos);
        end
        1: begin
          // \u with a bad digit after zero to three good ones
          queue_byte(jsu_pkg::CH_QUOTE, 1'b0);
          queue_byte(jsu_pkg::CH_BSL, 1'b0);
          queue_byte(jsu_pkg::CH_U, 1'b0);
          repeat ($urandom_range(0, 3)) queue_byte(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
          do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
          queue_byte(c, 1'($urandom_range(0, 1)));
        end
        2: begin
          // opening quote missing
          for (k = 1; k < s.size(); k++) queue_byte(s[k], 1'b0);
        end
        default: queue_byte(jsu_pkg::CH_QUOTE, 1'b1);
      endcase
    end
  endtask

  // input driver: one queued byte per word, random gap before each
  always @(posedge clk) begin : feed_proc
    int h;
    bit busy;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      feed_hold <= 0;
    end else begin
      h    = feed_hold;
      busy = in_valid;
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
        busy = 1'b0;
        h    = draw_wait(feed_calm);
      end
      if (!busy) begin
        if (h == 0 && text_q.size() > 0) begin
          in_data  <= text_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (h > 0) h--;
        end
      end
      feed_hold <= h;
    end
  end

  // result monitor: compare each accepted word, then stall for a while
  always @(posedge clk) begin : sink_proc
    jsu_pkg::out_word_t want;
    int                 h;
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_hold <= 0;
    end else begin
      h = sink_hold;
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected word", int'(out_data), 0);
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(out_data.out_byte), int'(want.out_byte));
          if (out_data.out_kind !== want.out_kind)
            report_mismatch("out_kind", int'(out_data.out_kind), int'(want.out_kind));
          if (out_data.run_last !== want.run_last)
            report_mismatch("run_last", int'(out_data.run_last), int'(want.run_last));
        end
        h = draw_wait(sink_calm);
      end
      if (h > 0) begin
        out_stall <= 1'b1;
        h--;
      end else begin
        out_stall <= 1'b0;
      end
      sink_hold <= h;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    err_cnt    = 0;
    cyc        = 0;
    feed_calm  = 1'b0;
    sink_calm  = 1'b0;
    dec_phase  = PH_AWAIT;
    dec_digits = '0;
    dec_cp     = '0;

    // opening quote that is also the final byte
    queue_byte(jsu_pkg::CH_QUOTE, 1'b1);
    // byte extremes, two escapes, top code point, close, then a stray byte
    queue_byte(jsu_pkg::CH_QUOTE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(jsu_pkg::CH_BSL, 1'b0);
    queue_byte(CH_B, 1'b0);
    queue_byte(jsu_pkg::CH_BSL, 1'b0);
    queue_byte(CH_T, 1'b0);
    queue_byte(jsu_pkg::CH_BSL, 1'b0);
    queue_byte(jsu_pkg::CH_U, 1'b0);
    queue_byte(8'h46, 1'b0);
    queue_byte(8'h66, 1'b0);
    queue_byte(8'h46, 1'b0);
    queue_byte(8'h66, 1'b0);
    queue_byte(jsu_pkg::CH_QUOTE, 1'b0);
    queue_byte(8'h41, 1'b0);
    // bad hex digit
    queue_byte(jsu_pkg::CH_QUOTE, 1'b0);
    queue_byte(jsu_pkg::CH_BSL, 1'b0);
    queue_byte(jsu_pkg::CH_U, 1'b0);
    queue_byte(8'h47, 1'b0);
    // text ends on the last digit of a complete \u escape
    queue_byte(jsu_pkg::CH_QUOTE, 1'b0);
    queue_byte(jsu_pkg::CH_BSL, 1'b0);
    queue_byte(jsu_pkg::CH_U, 1'b0);
    queue_byte(CH_0, 1'b0);
    queue_byte(CH_0, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h31, 1'b1);

    while (text_q.size() < RAND_BYTES + 27) add_text();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything fed, every word back, then a short settle
    while (text_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
